// ----- rtl/doubly_linked_list_manager_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the linked list manager
// Shared concurrent-assertion templates, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DLLM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dllm: same-cycle check failed");

// Next-cycle implication.
`define DLLM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dllm: next-cycle check failed");

`endif

// ----- rtl/dllm_pkg.sv -----
// ---------------------------------------------------------------------------
// dllm_pkg
// Shared widths, operation codes and controller/datapath handshake types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dllm_pkg;

    localparam int NODE_W    = 6;            // width of a node index
    localparam int CNT_W     = 7;            // width of the member count
    localparam int NODE_SPAN = 2 ** NODE_W;  // nodes addressable by the index field

    // Operation codes of the kind field
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic capture;  // latch item, launch link reads
        logic exec;     // apply updates, load result register
    } dllm_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic result_busy;  // result register full and not taken this cycle
    } dllm_status_t;

endpackage

// ----- rtl/dllm_if.sv -----
// ---------------------------------------------------------------------------
// dllm_req_if / dllm_rsp_if
// Valid/ready channels for list operations and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dllm_req_if import dllm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [NODE_W-1:0] node;

    modport source (output valid, output kind, output node, input ready);
    modport sink   (input valid, input kind, input node, output ready);
endinterface

interface dllm_rsp_if import dllm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              applied;
    logic [CNT_W-1:0]  member_count;
    logic [NODE_W-1:0] head_node;
    logic              head_valid;
    logic [NODE_W-1:0] tail_node;

    modport source (output valid, output applied, output member_count, output head_node,
                    output head_valid, output tail_node, input ready);
    modport sink   (input valid, input applied, input member_count, input head_node,
                    input head_valid, input tail_node, output ready);
endinterface

// ----- rtl/dllm_ctrl.sv -----
// ---------------------------------------------------------------------------
// dllm_ctrl
// Two-state sequencer: take a transfer, then execute it against the links.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dllm_ctrl import dllm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  dllm_status_t status,
    output dllm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register can take the new result
                if (!status.result_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dllm_datapath.sv -----
// ---------------------------------------------------------------------------
// dllm_datapath
// Link memories, head/tail/count registers and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "doubly_linked_list_manager_core_defines.svh"

module dllm_datapath import dllm_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dllm_cmd_t         cmd,
    output dllm_status_t      status,
    input  logic              req_kind,
    input  logic [NODE_W-1:0] req_node,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              rsp_applied,
    output logic [CNT_W-1:0]  rsp_member_count,
    output logic [NODE_W-1:0] rsp_head_node,
    output logic              rsp_head_valid,
    output logic [NODE_W-1:0] rsp_tail_node
);

    // only the first NODE_SPAN pool entries can ever be named by an item
    localparam int DEPTH = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // link index storage; link valid bits live in flops so reset nulls all links
    logic [NODE_W-1:0] prev_mem [DEPTH];
    logic [NODE_W-1:0] next_mem [DEPTH];
    logic [DEPTH-1:0]  prev_vld_reg, prev_vld_next;
    logic [DEPTH-1:0]  next_vld_reg, next_vld_next;

    logic              kind_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] prev_rd_reg;
    logic [NODE_W-1:0] next_rd_reg;

    logic [NODE_W-1:0] first_reg, first_next;
    logic [NODE_W-1:0] last_reg, last_next;
    logic              nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              applied;

    logic              out_valid_reg;
    logic              out_applied_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [NODE_W-1:0] out_head_reg;
    logic              out_head_vld_reg;
    logic [NODE_W-1:0] out_tail_reg;

    // write ports
    logic              pwr_en, pwr_v;
    logic [AW-1:0]     pwr_addr;
    logic [NODE_W-1:0] pwr_data;
    logic              nwr_en, nwr_v;
    logic [AW-1:0]     nwr_addr;
    logic [NODE_W-1:0] nwr_data;
    logic              pclr, nclr;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     n_addr;
    logic              node_ok;
    logic              p_v, q_v;
    logic [CNT_W-1:0]  count_dec;

    assign rd_addr   = AW'(req_node);
    assign n_addr    = AW'(node_reg);
    assign node_ok   = ({1'b0, node_reg} < DEPTH_CNT);
    assign count_dec = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        first_next    = first_reg;
        last_next     = last_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        applied       = 1'b0;
        pwr_en        = 1'b0;
        pwr_v         = 1'b0;
        pwr_addr      = n_addr;
        pwr_data      = '0;
        nwr_en        = 1'b0;
        nwr_v         = 1'b0;
        nwr_addr      = n_addr;
        nwr_data      = '0;
        pclr          = 1'b0;
        nclr          = 1'b0;
        p_v           = 1'b0;
        q_v           = 1'b0;
        if (node_ok)
        begin
            p_v = prev_vld_reg[n_addr];
            q_v = next_vld_reg[n_addr];
            if (kind_reg == KIND_APPEND)
            begin
                if (!nonempty_reg)
                begin
                    first_next    = node_reg;
                    last_next     = node_reg;
                    nonempty_next = 1'b1;
                    pclr          = 1'b1;
                    nclr          = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    applied       = 1'b1;
                end
                else if (!(q_v || (last_reg == node_reg)))
                begin
                    // link behind the current tail
                    pwr_en     = 1'b1;
                    pwr_v      = 1'b1;
                    pwr_addr   = n_addr;
                    pwr_data   = last_reg;
                    nclr       = 1'b1;
                    nwr_en     = 1'b1;
                    nwr_v      = 1'b1;
                    nwr_addr   = AW'(last_reg);
                    nwr_data   = node_reg;
                    last_next  = node_reg;
                    count_next = count_reg + CNT_W'(1);
                    applied    = 1'b1;
                end
            end
            else if (nonempty_reg)
            begin
                if (p_v)
                begin
                    // predecessor takes over our next link
                    nwr_en   = 1'b1;
                    nwr_v    = q_v;
                    nwr_addr = AW'(prev_rd_reg);
                    nwr_data = next_rd_reg;
                    pclr     = 1'b1;
                    if (q_v)
                    begin
                        pwr_en   = 1'b1;
                        pwr_v    = 1'b1;
                        pwr_addr = AW'(next_rd_reg);
                        pwr_data = prev_rd_reg;
                        nclr     = 1'b1;
                    end
                    else
                    begin
                        last_next = prev_rd_reg;
                    end
                    count_next = count_dec;
                    applied    = 1'b1;
                end
                else if (q_v)
                begin
                    // removing the head
                    pwr_en     = 1'b1;
                    pwr_v      = 1'b0;
                    pwr_addr   = AW'(next_rd_reg);
                    nclr       = 1'b1;
                    first_next = next_rd_reg;
                    count_next = count_dec;
                    applied    = 1'b1;
                end
                else if (node_reg == first_reg)
                begin
                    // sole member leaves
                    first_next    = '0;
                    last_next     = '0;
                    nonempty_next = 1'b0;
                    count_next    = count_dec;
                    applied       = 1'b1;
                end
            end
        end
    end

    // valid-bit updates; clear-then-write on prev, write-then-clear on next
    always_comb
    begin
        prev_vld_next = prev_vld_reg;
        next_vld_next = next_vld_reg;
        if (pclr)
        begin
            prev_vld_next[n_addr] = 1'b0;
        end
        if (pwr_en)
        begin
            prev_vld_next[pwr_addr] = pwr_v;
        end
        if (nwr_en)
        begin
            next_vld_next[nwr_addr] = nwr_v;
        end
        if (nclr)
        begin
            next_vld_next[n_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= req_kind;
            node_reg    <= req_node;
            prev_rd_reg <= prev_mem[rd_addr];
            next_rd_reg <= next_mem[rd_addr];
        end
        if (cmd.exec && pwr_en)
        begin
            prev_mem[pwr_addr] <= pwr_data;
        end
        if (cmd.exec && nwr_en)
        begin
            next_mem[nwr_addr] <= nwr_data;
        end
        if (cmd.exec)
        begin
            out_applied_reg  <= applied;
            out_count_reg    <= count_next;
            out_head_reg     <= nonempty_next ? first_next : '0;
            out_head_vld_reg <= nonempty_next;
            out_tail_reg     <= nonempty_next ? last_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vld_reg  <= '0;
            next_vld_reg  <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            nonempty_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                prev_vld_reg <= prev_vld_next;
                next_vld_reg <= next_vld_next;
                first_reg    <= first_next;
                last_reg     <= last_next;
                nonempty_reg <= nonempty_next;
                count_reg    <= count_next;
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.result_busy = out_valid_reg && !rsp_ready;

    assign rsp_valid        = out_valid_reg;
    assign rsp_applied      = out_applied_reg;
    assign rsp_member_count = out_count_reg;
    assign rsp_head_node    = out_head_reg;
    assign rsp_head_valid   = out_head_vld_reg;
    assign rsp_tail_node    = out_tail_reg;

    `DLLM_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.exec, !(out_valid_reg && !rsp_ready))
    `DLLM_ASSERT_NXT(a_result_loaded, clk, rst_n, cmd.exec, out_valid_reg)
    `DLLM_ASSERT_IMP(a_empty_zero, clk, rst_n, !nonempty_reg, count_reg == '0 && first_reg == '0 && last_reg == '0)
    `DLLM_ASSERT_IMP(a_count_flag, clk, rst_n, 1'b1, nonempty_reg == (count_reg != '0))
    `DLLM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)

endmodule

// ----- rtl/doubly_linked_list_manager_core.sv -----
// A request transfer captures the item and launches the link reads
//   (registered memory read); exec then applies the link update/write
//   back and loads the result register, unless a result stall holds it.
// A new request is taken only after the previous item has left exec.
// A result not yet taken holds the following item in exec, so request
//   transfers stop until the receiver takes it.
// Reset clears head, tail, count and all link valid bits.
// ---------------------------------------------------------------------------
// doubly_linked_list_manager_core
// Doubly linked list over a pool of node indices: append at tail, remove.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_list_manager_core import dllm_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    dllm_req_if.sink    req,
    dllm_rsp_if.source  rsp
);

    // Command/status between the sequencer and the datapath.
    dllm_cmd_t    cmd;
    dllm_status_t status;

    // Sequencer: idle accepts a transfer and launches the link reads;
    // exec applies the update once the result register is free.
    dllm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: prev/next link memories with flop valid bits, list
    // registers, and the output register that holds a result until taken.
    dllm_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .req_kind         (req.kind),
        .req_node         (req.node),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_applied      (rsp.applied),
        .rsp_member_count (rsp.member_count),
        .rsp_head_node    (rsp.head_node),
        .rsp_head_valid   (rsp.head_valid),
        .rsp_tail_node    (rsp.tail_node)
    );

endmodule
